FILE: src/zeckendorf_adder_unit_defines.svh
// Assertion macros for the Zeckendorf adder unit.
// Used by the top level; needs clk_i and rst_ni in scope.
`ifndef ZECKENDORF_ADDER_UNIT_DEFINES_SVH
`define ZECKENDORF_ADDER_UNIT_DEFINES_SVH

// same-cycle implication
`define ZAU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("zeckendorf_adder_unit: assertion failed");

// next-cycle implication
`define ZAU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("zeckendorf_adder_unit: assertion failed");

`endif

FILE: src/zeck_pkg.sv
// Shared constants, controller states and command/status types
// for the Zeckendorf adder unit. No dependencies.
`default_nettype none

package zeck_pkg;

  localparam int unsigned DIGITS_DEF = 32;
  localparam int unsigned IN_W       = 32;
  localparam int unsigned SUM_W      = 34;
  localparam int unsigned SUM_CNT_W  = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_CONV,
    ST_PUB
  } state_e;

  typedef struct packed {
    logic load;
    logic accum;
    logic conv;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic invalid;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/zeck_ctrl.sv
// Controller state machine of the Zeckendorf adder unit.
// Depends on zeck_pkg for states and command/status types.
`default_nettype none

module zeck_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire zeck_pkg::sts_t sts_i,
  output zeck_pkg::cmd_t      cmd_o
);

  zeck_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= zeck_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      zeck_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = zeck_pkg::ST_ACCUM;
        end
      end
      zeck_pkg::ST_ACCUM: begin
        if (sts_i.invalid) begin
          state_d = zeck_pkg::ST_PUB;
        end else begin
          cmd_o.accum = 1'b1;
          if (sts_i.last) begin
            state_d = zeck_pkg::ST_CONV;
          end
        end
      end
      zeck_pkg::ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (sts_i.last) begin
          state_d = zeck_pkg::ST_PUB;
        end
      end
      zeck_pkg::ST_PUB: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.publish = 1'b1;
          state_d       = zeck_pkg::ST_IDLE;
        end
      end
      default: state_d = zeck_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != zeck_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: src/zeck_dpath.sv
// Datapath of the Zeckendorf adder unit: value accumulation, greedy
// re-encoding and the output register. Depends on zeck_pkg.
`default_nettype none

module zeck_dpath #(
  parameter int unsigned DIGITS = zeck_pkg::DIGITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire zeck_pkg::cmd_t                 cmd_i,
  output zeck_pkg::sts_t                      sts_o,
  input  wire logic [zeck_pkg::IN_W-1:0]      addend_a_i,
  input  wire logic [zeck_pkg::IN_W-1:0]      addend_b_i,
  output logic      [zeck_pkg::SUM_W-1:0]     sum_word_o,
  output logic      [zeck_pkg::SUM_CNT_W-1:0] sum_digits_o,
  output logic                                input_invalid_o
);

  localparam int unsigned POS   = DIGITS + 2;
  localparam int unsigned VAL_W = ((DIGITS + 4) * 7) / 10 + 2;
  localparam int unsigned CNT_W = $clog2(POS);
  localparam int unsigned CW    = $clog2(POS + 1);
  localparam int unsigned EXT_W = (POS > zeck_pkg::SUM_W) ? POS : zeck_pkg::SUM_W;
  localparam logic [zeck_pkg::IN_W-1:0] IN_MASK =
    zeck_pkg::IN_W'((64'(1) << DIGITS) - 64'(1));
  localparam int unsigned CNT_MAX = (1 << zeck_pkg::SUM_CNT_W) - 1;

  logic [zeck_pkg::IN_W-1:0] a_q, a_d, b_q, b_d;
  logic [VAL_W-1:0]          v_q, v_d, f0_q, f0_d, f1_q, f1_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [CW-1:0]             len_q, len_d;
  logic [POS-1:0]            word_q, word_d;
  logic                      inv_q, inv_d;
  logic [zeck_pkg::IN_W-1:0] a_m, b_m;
  logic [VAL_W-1:0]          term;
  logic                      take;
  logic [EXT_W-1:0]          word_ext;
  logic [7:0]                len8;

  assign a_m  = addend_a_i & IN_MASK;
  assign b_m  = addend_b_i & IN_MASK;
  assign take = (f1_q <= v_q);

  always_comb begin
    unique case ({a_q[0], b_q[0]})
      2'b11:          term = {f0_q[VAL_W-2:0], 1'b0};
      2'b10, 2'b01:   term = f0_q;
      default:        term = '0;
    endcase
  end

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    v_d    = v_q;
    f0_d   = f0_q;
    f1_d   = f1_q;
    cnt_d  = cnt_q;
    len_d  = len_q;
    word_d = word_q;
    inv_d  = inv_q;
    priority if (cmd_i.load) begin
      a_d    = a_m;
      b_d    = b_m;
      v_d    = '0;
      f0_d   = VAL_W'(1);
      f1_d   = VAL_W'(2);
      cnt_d  = CNT_W'(DIGITS - 1);
      len_d  = '0;
      word_d = '0;
      inv_d  = ((a_m & (a_m >> 1)) != '0) || ((b_m & (b_m >> 1)) != '0);
    end else if (cmd_i.accum) begin
      a_d   = a_q >> 1;
      b_d   = b_q >> 1;
      v_d   = v_q + term;
      f0_d  = f1_q;
      f1_d  = f0_q + f1_q;
      cnt_d = (cnt_q == '0) ? CNT_W'(POS - 1) : cnt_q - CNT_W'(1);
    end else if (cmd_i.conv) begin
      if (take) begin
        v_d = v_q - f1_q;
        if (len_q == '0) begin
          len_d = CW'(cnt_q) + CW'(1);
        end
      end
      f1_d   = f0_q;
      f0_d   = f1_q - f0_q;
      word_d = {word_q[POS-2:0], take};
      cnt_d  = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
    end else begin
      inv_q <= inv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    v_q    <= v_d;
    f0_q   <= f0_d;
    f1_q   <= f1_d;
    cnt_q  <= cnt_d;
    len_q  <= len_d;
    word_q <= word_d;
  end

  assign sts_o.last    = (cnt_q == '0);
  assign sts_o.invalid = inv_q;

  assign word_ext = EXT_W'(word_q);
  assign len8     = 8'(len_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      input_invalid_o <= inv_q;
      if (inv_q) begin
        sum_word_o   <= '0;
        sum_digits_o <= '0;
      end else begin
        sum_word_o   <= word_ext[zeck_pkg::SUM_W-1:0];
        sum_digits_o <= (len8 > 8'(CNT_MAX)) ? zeck_pkg::SUM_CNT_W'(CNT_MAX)
                                             : len8[zeck_pkg::SUM_CNT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/zeckendorf_adder_unit.sv
// Top level of the Zeckendorf adder unit: controller, datapath, checks.
// Depends on zeck_pkg, zeck_ctrl, zeck_dpath and the defines header.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------
//   in      | in_valid_i / in_stall_o | addend_a_i, addend_b_i
//   out     | out_valid_o/out_stall_i | sum_word_o, sum_digits_o,
//           |                         | input_invalid_o
//
// One beat runs from accept to result as a load, a pass summing digit weights
// one position at a time, a pass of greedy re-encoding from the top position,
// and a publish. An addend with adjacent ones skips both passes and goes
// straight to the publish.
// Reset clears the controller and the invalid flag only; no clearing pass.
// The next beat is taken while a result waits on a stalled output.
`default_nettype none

`include "zeckendorf_adder_unit_defines.svh"

module zeckendorf_adder_unit #(
  parameter int unsigned DIGITS = zeck_pkg::DIGITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [zeck_pkg::IN_W-1:0]      addend_a_i,
  input  wire logic [zeck_pkg::IN_W-1:0]      addend_b_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [zeck_pkg::SUM_W-1:0]     sum_word_o,
  output logic      [zeck_pkg::SUM_CNT_W-1:0] sum_digits_o,
  output logic                                input_invalid_o
);

  zeck_pkg::cmd_t cmd;
  zeck_pkg::sts_t sts;

  zeck_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  zeck_dpath #(
    .DIGITS (DIGITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .addend_a_i      (addend_a_i),
    .addend_b_i      (addend_b_i),
    .sum_word_o      (sum_word_o),
    .sum_digits_o    (sum_digits_o),
    .input_invalid_o (input_invalid_o)
  );

  `ZAU_ASSERT_IMP(a_invalid_zero, out_valid_o && input_invalid_o,
                  sum_word_o == '0 && sum_digits_o == '0)
  `ZAU_ASSERT_IMP(a_no_adjacent, out_valid_o,
                  (sum_word_o & (sum_word_o >> 1)) == '0)
  `ZAU_ASSERT_IMP(a_zero_len, out_valid_o && sum_digits_o == '0, sum_word_o == '0)
  `ZAU_ASSERT_NXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o)

endmodule

`default_nettype wire
